// ----- design/rwpf_pkg.sv -----
`default_nettype none

package rwpf_pkg;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [15:0] register_address;
        logic [31:0] write_value;
    } rwpf_req_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } rwpf_pkt_t;

    localparam logic [7:0]  HDR_SYNC     = 8'hFF;
    localparam logic [7:0]  HDR_MARK     = 8'hFD;
    localparam logic [7:0]  RESERVED     = 8'h00;
    localparam logic [7:0]  LEN_LO       = 8'h09;
    localparam logic [7:0]  LEN_HI       = 8'h00;
    localparam logic [7:0]  INSTR_WRITE  = 8'h03;
    localparam logic [15:0] CRC_POLY     = 16'h8005;

    localparam logic [3:0]  POS_HDR0     = 4'd0;
    localparam logic [3:0]  POS_HDR1     = 4'd1;
    localparam logic [3:0]  POS_HDR2     = 4'd2;
    localparam logic [3:0]  POS_RSVD     = 4'd3;
    localparam logic [3:0]  POS_ID       = 4'd4;
    localparam logic [3:0]  POS_LEN_LO   = 4'd5;
    localparam logic [3:0]  POS_LEN_HI   = 4'd6;
    localparam logic [3:0]  POS_INSTR    = 4'd7;
    localparam logic [3:0]  POS_ADDR_LO  = 4'd8;
    localparam logic [3:0]  POS_ADDR_HI  = 4'd9;
    localparam logic [3:0]  POS_VAL0     = 4'd10;
    localparam logic [3:0]  POS_VAL1     = 4'd11;
    localparam logic [3:0]  POS_VAL2     = 4'd12;
    localparam logic [3:0]  POS_CRC_LO   = 4'd14;
    localparam logic [3:0]  POS_LAST     = 4'd15;

    // Packet body byte at a position below the CRC field.
    function automatic logic [7:0] body_byte(input logic [3:0] pos, input rwpf_req_t req);
        logic [7:0] b;
        case (pos)
            POS_HDR0:    b = HDR_SYNC;
            POS_HDR1:    b = HDR_SYNC;
            POS_HDR2:    b = HDR_MARK;
            POS_RSVD:    b = RESERVED;
            POS_ID:      b = req.device_id;
            POS_LEN_LO:  b = LEN_LO;
            POS_LEN_HI:  b = LEN_HI;
            POS_INSTR:   b = INSTR_WRITE;
            POS_ADDR_LO: b = req.register_address[7:0];
            POS_ADDR_HI: b = req.register_address[15:8];
            POS_VAL0:    b = req.write_value[7:0];
            POS_VAL1:    b = req.write_value[15:8];
            POS_VAL2:    b = req.write_value[23:16];
            default:     b = req.write_value[31:24];
        endcase
        return b;
    endfunction

    // One byte through the MSB-first CRC-16, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/rwpf_front.sv -----
`default_nettype none

module rwpf_front
    import rwpf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire rwpf_req_t req,
    output logic           q_valid,
    input  wire logic      q_pop,
    output rwpf_req_t      q_data
);

    // Two-entry queue: head is always the entry handed to the back end.
    rwpf_req_t head_reg, tail_reg;
    logic      head_v_reg, tail_v_reg;
    logic      push;

    assign req_ready = !tail_v_reg;
    assign push      = req_valid && req_ready;
    assign q_valid   = head_v_reg;
    assign q_data    = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end
        else
        begin
            if (q_pop && push)
            begin
                head_reg   <= req;
                head_v_reg <= 1'b1;
            end
            else if (q_pop)
            begin
                // advance the tail into the head
                head_reg   <= tail_reg;
                head_v_reg <= tail_v_reg;
                tail_v_reg <= 1'b0;
            end
            else if (push)
            begin
                if (head_v_reg)
                begin
                    tail_reg   <= req;
                    tail_v_reg <= 1'b1;
                end
                else
                begin
                    head_reg   <= req;
                    head_v_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/rwpf_back.sv -----
`default_nettype none

module rwpf_back
    import rwpf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    output logic           q_pop,
    input  wire rwpf_req_t q_data,
    output logic           pkt_valid,
    input  wire logic      pkt_ready,
    output rwpf_pkt_t      pkt
);

    logic       busy_reg;
    logic [3:0] pos_reg;
    rwpf_req_t  req_reg;
    logic [15:0] crc_reg;
    logic       pkt_valid_reg;
    rwpf_pkt_t  pkt_reg;

    logic       advance;
    logic       finishing;
    logic [7:0] cur_byte;

    assign advance   = busy_reg && (!pkt_valid_reg || pkt_ready);
    assign finishing = advance && (pos_reg == POS_LAST);
    assign q_pop     = q_valid && (!busy_reg || finishing);
    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

    always_comb
    begin
        if (pos_reg < POS_CRC_LO)
        begin
            cur_byte = body_byte(pos_reg, req_reg);
        end
        else if (pos_reg == POS_CRC_LO)
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = crc_reg[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pkt_reg.packet_byte <= cur_byte;
                pkt_reg.last_byte   <= (pos_reg == POS_LAST);
                pkt_valid_reg       <= 1'b1;
                if (pos_reg < POS_CRC_LO)
                begin
                    crc_reg <= crc_byte(crc_reg, cur_byte);
                end
                // wraps to zero after the last byte, ready for the next request
                pos_reg <= pos_reg + 4'd1;
            end
            else if (pkt_ready)
            begin
                pkt_valid_reg <= 1'b0;
            end

            if (q_pop)
            begin
                // load the next request and restart the CRC
                req_reg  <= q_data;
                crc_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (finishing)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/register_write_packet_framer.sv -----
// Channel  Direction  Handshake               Word
// req      in         req_valid / req_ready   device_id, register_address, write_value
// pkt      out        pkt_valid / pkt_ready   packet_byte, last_byte
//
// Each request word turns into sixteen packet words, one per cycle while pkt_ready
// stays high; the byte sequencer in the back end walks the positions of each packet.
// On an idle block a request word goes through the queue head, req_reg and then pkt_reg.
// rst_n clears the queue, the sequencer and the output register at once.
// A stall on pkt holds the output word; the two-entry queue keeps taking requests
// until it is full.
`default_nettype none

module register_write_packet_framer
    import rwpf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire rwpf_req_t req,
    output logic           pkt_valid,
    input  wire logic      pkt_ready,
    output rwpf_pkt_t      pkt
);

    // Queue hand-off between the request front end and the byte sequencer.
    logic      q_valid;
    logic      q_pop;
    rwpf_req_t q_data;

    // Front end: take request words and hold them until the sequencer is free.
    rwpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data)
    );

    // Back end: walk the sixteen packet positions, fold body bytes into the CRC,
    // and drive each word through the output register.
    rwpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt)
    );

endmodule

`default_nettype wire

// ----- design/rwpf_checker.sv -----
`default_nettype none

module rwpf_checker
    import rwpf_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_ready,
    input wire logic      pkt_valid,
    input wire logic      pkt_ready,
    input wire rwpf_pkt_t pkt
);

    logic [3:0] count_reg, count_next;
    logic [2:0] pending_reg, pending_next;
    logic       req_acc, pkt_acc, pkt_done;

    assign req_acc  = req_valid && req_ready;
    assign pkt_acc  = pkt_valid && pkt_ready;
    assign pkt_done = pkt_acc && pkt.last_byte;

    always_comb
    begin
        count_next   = pkt_acc ? count_reg + 4'd1 : count_reg;
        pending_next = pending_reg + {2'b00, req_acc} - {2'b00, pkt_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
        else $error("output word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_acc |-> (pkt.last_byte == (count_reg == POS_LAST)))
        else $error("last_byte out of place");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_acc && (count_reg == POS_HDR0 || count_reg == POS_HDR1)
            |-> pkt.packet_byte == HDR_SYNC)
        else $error("bad sync byte");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_acc && (count_reg == POS_HDR0) |-> pending_reg != 3'd0)
        else $error("packet started without a request");

endmodule

bind register_write_packet_framer rwpf_checker u_rwpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
);

`default_nettype wire
